@@ rtl/tms_pkg.sv @@
`timescale 1ns / 1ps

package tms_pkg;

    // Template length and sample width.
    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;

    // Derived widths.
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);
    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int PROD_W    = 2 * SAMPLE_BITS + 1;
    localparam int SCORE_W   = 38;

    // Fixed field widths of the ports.
    localparam int TAP_CFG_W   = 7;
    localparam int TAP_INDEX_W = 6;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept_load;
        logic accept_sample;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic issue_last;
        logic pipe_busy;
    } status_t;

endpackage

@@ rtl/tms_ram.sv @@
`timescale 1ns / 1ps

module tms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tms_ctrl.sv @@
`timescale 1ns / 1ps

module tms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             req_type,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  tms_pkg::status_t status,
    output tms_pkg::cmd_t    cmd
);

    import tms_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (req_type == REQ_SAMPLE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept_load   = in_take && (req_type == REQ_LOAD);
                cmd.accept_sample = in_take && (req_type == REQ_SAMPLE);
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/tms_dp.sv @@
`timescale 1ns / 1ps

module tms_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [tms_pkg::TAP_CFG_W-1:0]       cfg_taps,
    input  logic signed [tms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                record_start,
    input  logic [tms_pkg::TAP_INDEX_W-1:0]     tap_index,
    input  logic signed [tms_pkg::SAMPLE_BITS-1:0] tap_value,
    input  tms_pkg::cmd_t                       cmd,
    output tms_pkg::status_t                    status,
    output logic [tms_pkg::SCORE_W-1:0]         match_score
);

    import tms_pkg::*;

    logic [TAP_CFG_W-1:0]          tap_cfg_reg;
    logic [CNT_W-1:0]              taps_reg;
    logic [CNT_W-1:0]              taps_clamped;
    logic [CNT_W-1:0]              seen_reg;
    logic [CNT_W-1:0]              seen_eff;
    logic signed [SAMPLE_BITS-1:0] first_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic [TAP_IDX_W-1:0]          wr_ptr_reg;
    logic [TAP_IDX_W-1:0]          j_reg;
    logic [CNT_W-1:0]              back;
    logic [TAP_IDX_W-1:0]          hist_rd_addr;
    logic                          tmpl_wr_en;
    logic signed [SAMPLE_BITS-1:0] tmpl_rd_data;
    logic signed [SAMPLE_BITS-1:0] hist_rd_data;

    logic                          valid_s1_reg;
    logic                          use_hist_s1_reg;
    logic                          valid_s2_reg;
    logic signed [DIFF_W-1:0]      diff_s2_reg;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [SAMPLE_BITS-1:0] pos_val;
    logic                          valid_s3_reg;
    logic [PROD_W-1:0]             prod_s3_reg;
    logic signed [2*DIFF_W-1:0]    square;
    logic [SCORE_W-1:0]            acc_reg;
    logic [SCORE_W-1:0]            score_reg;

    // Configuration register, reset to the full template length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_cfg_reg <= TAP_CFG_W'(MAX_TAPS);
        end
        else if (cfg_wr)
        begin
            tap_cfg_reg <= cfg_taps;
        end
    end

    always_comb
    begin
        if (tap_cfg_reg == '0)
        begin
            taps_clamped = CNT_W'(1);
        end
        else if (tap_cfg_reg > TAP_CFG_W'(MAX_TAPS))
        begin
            taps_clamped = CNT_W'(MAX_TAPS);
        end
        else
        begin
            taps_clamped = CNT_W'(tap_cfg_reg);
        end
    end

    assign seen_eff = record_start ? '0 : seen_reg;

    // Per-record control state and history write pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            wr_ptr_reg <= '0;
            first_reg  <= '0;
            j_reg      <= '0;
            taps_reg   <= CNT_W'(1);
        end
        else
        begin
            if (cmd.accept_sample)
            begin
                seen_reg <= seen_eff;
                taps_reg <= taps_clamped;
                j_reg    <= '0;
                if (seen_eff == '0)
                begin
                    first_reg <= sample;
                end
            end
            else if (cmd.issue)
            begin
                j_reg <= j_reg + 1'b1;
            end
            else if (cmd.finish)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                if (seen_reg != CNT_W'(MAX_TAPS))
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_sample)
        begin
            cur_reg <= sample;
        end
    end

    // Tap j pairs with the sample that lies taps - j items back.
    assign back              = taps_reg - CNT_W'(j_reg);
    assign hist_rd_addr      = wr_ptr_reg - TAP_IDX_W'(back);
    assign status.issue_last = (CNT_W'(j_reg) == taps_reg - 1'b1);
    assign status.pipe_busy  = valid_s1_reg || valid_s2_reg || valid_s3_reg;

    assign tmpl_wr_en = cmd.accept_load && (CNT_W'(tap_index) < CNT_W'(MAX_TAPS));

    tms_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tmpl_ram (
        .clk     (clk),
        .wr_en   (tmpl_wr_en),
        .wr_addr (TAP_IDX_W'(tap_index)),
        .wr_data (tap_value),
        .rd_addr (j_reg),
        .rd_data (tmpl_rd_data)
    );

    tms_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (cmd.finish),
        .wr_addr (wr_ptr_reg),
        .wr_data (cur_reg),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    // Difference, square and accumulate stages.
    assign pos_val   = use_hist_s1_reg ? hist_rd_data : first_reg;
    assign diff_next = DIFF_W'(pos_val) - DIFF_W'(tmpl_rd_data);
    assign square    = diff_s2_reg * diff_s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= cmd.issue;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        use_hist_s1_reg <= (back <= seen_reg);
        diff_s2_reg     <= diff_next;
        prod_s3_reg     <= PROD_W'(unsigned'(square));
        if (cmd.accept_sample)
        begin
            acc_reg <= '0;
        end
        else if (valid_s3_reg)
        begin
            acc_reg <= acc_reg + SCORE_W'(prod_s3_reg);
        end
        if (cmd.finish)
        begin
            score_reg <= acc_reg;
        end
    end

    assign match_score = score_reg;

endmodule

@@ rtl/template_match_ssd.sv @@
`timescale 1ns / 1ps

// Sliding sum-of-squared-differences template matcher. A load transfer
// (req_type high) writes one signed template tap. A sample transfer produces
// exactly one match_score: the exact sum, over the tap_count active taps, of
// the squared difference between each tap and the matching earlier sample,
// where window positions before the start of the record take the record's
// first sample. One shared square-accumulate unit walks the taps one per
// cycle. Once a sample is taken the input stalls while the template and
// history memories are read tap by tap, the difference, square and
// accumulate stages drain until they are seen empty, and the sum moves into
// the output register. That move waits while an earlier score is still
// stalled in the output register. The input takes the next item while an
// earlier score still waits in that register. tap_count is written through
// the configuration channel, which is always ready, and should change only
// while the block is idle; zero acts as one and values above 64 act as 64.

module template_match_ssd (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tms_pkg::TAP_CFG_W-1:0]          tap_count,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic signed [tms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   record_start,
    input  logic [tms_pkg::TAP_INDEX_W-1:0]        tap_index,
    input  logic signed [tms_pkg::SAMPLE_BITS-1:0] tap_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tms_pkg::SCORE_W-1:0]            match_score
);

    import tms_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The configuration register is a plain flop, so a write is always taken.
    assign cfg_ready = 1'b1;

    // The controller sequences accept, tap walk, drain and output load.
    tms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the template and history memories, the record
    // state and the square-accumulate pipeline.
    tms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_taps     (tap_count),
        .sample       (sample),
        .record_start (record_start),
        .tap_index    (tap_index),
        .tap_value    (tap_value),
        .cmd          (cmd),
        .status       (status),
        .match_score  (match_score)
    );

endmodule

@@ rtl/tms_checker.sv @@
`timescale 1ns / 1ps

module tms_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   req_type,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [tms_pkg::SCORE_W-1:0]            match_score
);

    import tms_pkg::*;

    // A stalled score stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("score dropped while stalled");

    // A stalled score keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(match_score))
        else $error("score changed while stalled");

    // A sample transfer starts a tap walk, so the input is busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_SAMPLE) |=> in_stall)
        else $error("input not busy after a sample transfer");

    // A template load leaves the input free again in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_LOAD) |=> !in_stall)
        else $error("input busy after a template load");

    // A new score appears only at the end of a tap walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("score appeared without a tap walk");

endmodule

bind template_match_ssd tms_checker u_tms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_score (match_score)
);
